// ----- rtl/dis_pkg.sv -----
// disjoint interval set: shared types, constants and codes
// no dependencies; used by every module of the block but dis_ram
package dis_pkg;

	localparam int VALUE_COUNT_DEF   = 1024;
	localparam int MAX_INTERVALS_DEF = 512;

	localparam int VAL_W = 10;
	localparam int IDX_W = 9;
	localparam int CNT_W = 10;
	localparam int ST_W  = 2;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic             opcode;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] read_index;
	} item_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] interval_start;
		logic [VAL_W-1:0] interval_end;
		logic [CNT_W-1:0] interval_count;
		logic [ST_W-1:0]  status;
	} item_out_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DISP, S_PR1, S_PR2, S_PR3, S_DECIDE,
		S_SC_RD, S_SC_CMP, S_ACT, S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR,
		S_RD1, S_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PS_LEFT, PS_CUR, PS_RIGHT
	} pres_sel_t;

	typedef enum logic [1:0] {
		RS_SCAN, RS_DN, RS_UP, RS_IDX
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_NONE, RES_OK, RES_IGN, RES_RANGE, RES_READ
	} res_t;

	typedef struct packed {
		logic      load_in;
		logic      clr_step;
		pres_sel_t pres_sel;
		logic      cap_left;
		logic      cap_cur;
		logic      cap_right;
		rd_sel_t   iv_sel;
		logic      j_clr;
		logic      j_inc;
		logic      j_dec;
		logic      j_from_count;
		logic      p_cap;
		logic      wr_merge;
		logic      wr_left;
		logic      wr_right;
		logic      wr_dn;
		logic      wr_up;
		logic      wr_ins;
		logic      cnt_inc;
		logic      cnt_dec;
		res_t      res;
		logic      out_load;
	} dis_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic left;
		logic right;
		logic cur;
		logic full;
		logic j_at_count;
		logic start_lt_v;
		logic dn_more;
		logic up_more;
		logic idx_ok;
		logic out_free;
	} dis_sts_t;

endpackage

// ----- rtl/dis_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module dis_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/dis_ctrl.sv -----
// disjoint interval set: controller state machine
// depends on dis_pkg; drives dis_dp through the command struct
module dis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  dis_pkg::dis_sts_t sts,
	output dis_pkg::dis_cmd_t cmd
);
	import dis_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLR:    if (sts.clr_done) state_nx = S_IDLE;
			S_IDLE:   if (op_valid) state_nx = S_DISP;
			S_DISP: begin
				if (!sts.is_read) state_nx = S_PR1;
				else if (sts.idx_ok) state_nx = S_RD1;
				else state_nx = S_DONE;
			end
			S_PR1:    state_nx = S_PR2;
			S_PR2:    state_nx = S_PR3;
			S_PR3:    state_nx = S_DECIDE;
			S_DECIDE: begin
				if (sts.cur || (!sts.left && !sts.right && sts.full)) state_nx = S_DONE;
				else state_nx = S_SC_RD;
			end
			S_SC_RD:  state_nx = sts.j_at_count ? S_ACT : S_SC_CMP;
			S_SC_CMP: state_nx = sts.start_lt_v ? S_SC_RD : S_ACT;
			S_ACT: begin
				if (sts.left && sts.right) state_nx = S_DN_RD;
				else if (sts.left || sts.right) state_nx = S_DONE;
				else state_nx = S_UP_RD;
			end
			S_DN_RD:  state_nx = sts.dn_more ? S_DN_WR : S_DONE;
			S_DN_WR:  state_nx = S_DN_RD;
			S_UP_RD:  state_nx = sts.up_more ? S_UP_WR : S_DONE;
			S_UP_WR:  state_nx = S_UP_RD;
			S_RD1:    state_nx = S_DONE;
			S_DONE:   if (sts.out_free) state_nx = S_IDLE;
			default:  state_nx = S_CLR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		op_ready = 1'b0;
		unique case (state_q)
			S_CLR:  cmd.clr_step = 1'b1;
			S_IDLE: begin
				op_ready    = 1'b1;
				cmd.load_in = op_valid;
			end
			S_DISP: begin
				if (!sts.is_read) begin
					cmd.pres_sel = PS_LEFT;
				end else if (sts.idx_ok) begin
					cmd.iv_sel = RS_IDX;
				end else begin
					cmd.res = RES_RANGE;
				end
			end
			S_PR1: begin
				cmd.cap_left = 1'b1;
				cmd.pres_sel = PS_CUR;
			end
			S_PR2: begin
				cmd.cap_cur  = 1'b1;
				cmd.pres_sel = PS_RIGHT;
			end
			S_PR3:  cmd.cap_right = 1'b1;
			S_DECIDE: begin
				if (sts.cur || (!sts.left && !sts.right && sts.full)) cmd.res = RES_IGN;
				else cmd.j_clr = 1'b1;
			end
			S_SC_RD: begin
				if (sts.j_at_count) begin
					cmd.p_cap = 1'b1;
				end else begin
					cmd.iv_sel = RS_SCAN;
				end
			end
			S_SC_CMP: begin
				if (sts.start_lt_v) cmd.j_inc = 1'b1;
				else cmd.p_cap = 1'b1;
			end
			S_ACT: begin
				if (sts.left && sts.right) begin
					cmd.wr_merge = 1'b1;
				end else if (sts.left) begin
					cmd.wr_left = 1'b1;
					cmd.res     = RES_OK;
				end else if (sts.right) begin
					cmd.wr_right = 1'b1;
					cmd.res      = RES_OK;
				end else begin
					cmd.j_from_count = 1'b1;
				end
			end
			S_DN_RD: begin
				if (sts.dn_more) begin
					cmd.iv_sel = RS_DN;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.res     = RES_OK;
				end
			end
			S_DN_WR: begin
				cmd.wr_dn = 1'b1;
				cmd.j_inc = 1'b1;
			end
			S_UP_RD: begin
				if (sts.up_more) begin
					cmd.iv_sel = RS_UP;
				end else begin
					cmd.wr_ins  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.res     = RES_OK;
				end
			end
			S_UP_WR: begin
				cmd.wr_up = 1'b1;
				cmd.j_dec = 1'b1;
			end
			S_RD1:  cmd.res = RES_READ;
			S_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/dis_dp.sv -----
// disjoint interval set: datapath with presence map, interval stores and result register
// depends on dis_pkg and dis_ram; steered by dis_ctrl
module dis_dp #(
	parameter int VALUE_COUNT   = dis_pkg::VALUE_COUNT_DEF,
	parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dis_pkg::item_in_t  op_item,
	output logic               res_valid,
	input  logic               res_ready,
	output dis_pkg::item_out_t res_item,
	input  dis_pkg::dis_cmd_t  cmd,
	output dis_pkg::dis_sts_t  sts
);
	import dis_pkg::*;

	localparam int PAW  = $clog2(VALUE_COUNT);
	localparam int IAW  = $clog2(MAX_INTERVALS);
	localparam int JW   = $clog2(MAX_INTERVALS + 1);
	localparam int CMPW = (IDX_W > JW) ? IDX_W : JW;

	logic             is_read_q;
	logic [VAL_W-1:0] v_q;
	logic [IDX_W-1:0] idx_q;
	logic             left_q, right_q, cur_q;
	logic [JW-1:0]    j_q, p_q, count_q;
	logic [VAL_W-1:0] endb_q;
	logic [PAW-1:0]   clr_q;
	logic [VAL_W-1:0] r_start_q, r_end_q;
	logic [ST_W-1:0]  r_status_q;
	logic             out_valid_q;
	item_out_t        out_q;

	logic             v_ok, has_left, has_right;
	logic [31:0]      v_ext;
	logic             pres_we, pres_wdata, pres_rdata;
	logic [PAW-1:0]   pres_waddr, pres_raddr;
	logic             st_we, en_we;
	logic [IAW-1:0]   st_waddr, en_waddr, iv_raddr;
	logic [VAL_W-1:0] st_wdata, en_wdata, st_rdata, en_rdata;
	logic [JW-1:0]    j_plus, j_minus, rd_j;
	logic [CMPW-1:0]  idx_w, cnt_w;
	logic [JW:0]      j_plus_w;

	assign v_ext     = 32'(v_q);
	assign v_ok      = v_ext < VALUE_COUNT;
	assign has_left  = v_ext > 32'd0;
	assign has_right = (v_ext + 32'd1) < VALUE_COUNT;
	assign j_plus    = j_q + JW'(1);
	assign j_minus   = j_q - JW'(1);
	assign j_plus_w  = {1'b0, j_q} + (JW+1)'(1);
	assign idx_w     = CMPW'(idx_q);
	assign cnt_w     = CMPW'(count_q);

	// presence map: cleared once after reset, then set by successful adds
	always_comb begin
		pres_we    = cmd.clr_step || (cmd.res == RES_OK);
		pres_waddr = cmd.clr_step ? clr_q : PAW'(v_ext);
		pres_wdata = !cmd.clr_step;
		unique case (cmd.pres_sel)
			PS_LEFT:  pres_raddr = PAW'(v_ext - 32'd1);
			PS_RIGHT: pres_raddr = PAW'(v_ext + 32'd1);
			default:  pres_raddr = PAW'(v_ext);
		endcase
	end

	dis_ram #(.WIDTH(1), .DEPTH(VALUE_COUNT)) u_pres (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (pres_raddr),
		.rdata (pres_rdata)
	);

	// interval stores: every write but the end of a merge or left extension lands at j
	always_comb begin
		st_we    = cmd.wr_right || cmd.wr_dn || cmd.wr_up || cmd.wr_ins;
		st_waddr = j_q[IAW-1:0];
		st_wdata = (cmd.wr_dn || cmd.wr_up) ? st_rdata : v_q;
		en_we    = cmd.wr_merge || cmd.wr_left || cmd.wr_dn || cmd.wr_up || cmd.wr_ins;
		en_waddr = (cmd.wr_merge || cmd.wr_left) ? j_minus[IAW-1:0] : j_q[IAW-1:0];
		if (cmd.wr_merge) en_wdata = endb_q;
		else if (cmd.wr_dn || cmd.wr_up) en_wdata = en_rdata;
		else en_wdata = v_q;
		unique case (cmd.iv_sel)
			RS_DN:   rd_j = j_plus;
			RS_UP:   rd_j = j_minus;
			default: rd_j = j_q;
		endcase
		iv_raddr = (cmd.iv_sel == RS_IDX) ? idx_w[IAW-1:0] : rd_j[IAW-1:0];
	end

	dis_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INTERVALS)) u_starts (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (iv_raddr),
		.rdata (st_rdata)
	);

	dis_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INTERVALS)) u_ends (
		.clk   (clk),
		.we    (en_we),
		.waddr (en_waddr),
		.wdata (en_wdata),
		.raddr (iv_raddr),
		.rdata (en_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			is_read_q <= (op_item.opcode == OP_READ);
			v_q       <= op_item.value;
			idx_q     <= op_item.read_index;
		end
		if (cmd.cap_left) left_q <= pres_rdata && has_left;
		if (cmd.cap_cur) cur_q <= pres_rdata || !v_ok;
		if (cmd.cap_right) right_q <= pres_rdata && has_right;
		if (cmd.p_cap) begin
			p_q    <= j_q;
			endb_q <= en_rdata;
		end
		unique case (cmd.res)
			RES_OK: begin
				r_start_q  <= '0;
				r_end_q    <= '0;
				r_status_q <= ST_OK;
			end
			RES_IGN: begin
				r_start_q  <= '0;
				r_end_q    <= '0;
				r_status_q <= ST_IGNORED;
			end
			RES_RANGE: begin
				r_start_q  <= '0;
				r_end_q    <= '0;
				r_status_q <= ST_RANGE;
			end
			RES_READ: begin
				r_start_q  <= st_rdata;
				r_end_q    <= en_rdata;
				r_status_q <= ST_OK;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_q.interval_start <= r_start_q;
			out_q.interval_end   <= r_end_q;
			out_q.interval_count <= CNT_W'(count_q);
			out_q.status         <= r_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_from_count) j_q <= count_q;
			else if (cmd.j_inc) j_q <= j_plus;
			else if (cmd.j_dec) j_q <= j_minus;
			if (cmd.cnt_inc) count_q <= count_q + JW'(1);
			else if (cmd.cnt_dec) count_q <= count_q - JW'(1);
			if (cmd.clr_step) clr_q <= clr_q + PAW'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_done   = (clr_q == PAW'(VALUE_COUNT - 1));
		sts.is_read    = is_read_q;
		sts.left       = left_q;
		sts.right      = right_q;
		sts.cur        = cur_q;
		sts.full       = (count_q == JW'(MAX_INTERVALS));
		sts.j_at_count = (j_q == count_q);
		sts.start_lt_v = (st_rdata < v_q);
		sts.dn_more    = (j_plus_w < {1'b0, count_q});
		sts.up_more    = (j_q > p_q);
		sts.idx_ok     = (idx_w < cnt_w);
		sts.out_free   = !out_valid_q || res_ready;
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

endmodule

// ----- rtl/disjoint_interval_set_unit.sv -----
// channel  | handshake             | payload
// op       | op_valid / op_ready   | op_item  (opcode, value, read_index)
// res      | res_valid / res_ready | res_item (interval_start, interval_end, interval_count, status)
//
// items are taken one at a time: op_ready rises again only once the last item has gone to the
// result register; an add that is not ignored takes longer the more intervals start below its
// value and the more intervals an insert or a removal moves, all bound by the one read and one
// write port of each interval store
// after reset the presence map is cleared one entry a cycle, op_ready low
// a finished item waits in the result register; a stalled res channel holds the next item
// in its last state until the register frees
// top level: joins the controller and the datapath; depends on dis_pkg, dis_ctrl, dis_dp
module disjoint_interval_set_unit #(
	parameter int VALUE_COUNT   = dis_pkg::VALUE_COUNT_DEF,
	parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  dis_pkg::item_in_t  op_item,
	output logic               res_valid,
	input  logic               res_ready,
	output dis_pkg::item_out_t res_item
);
	import dis_pkg::*;

	dis_cmd_t cmd;
	dis_sts_t sts;

	dis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dis_dp #(
		.VALUE_COUNT   (VALUE_COUNT),
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_item   (op_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
